[rtl/ofl_pkg.sv]
package ofl_pkg;

   localparam int DEPTH = 256;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam int PROC_W = 6;
   localparam int PAGE_W = 8;
   localparam int FRAME_W = 8;
   localparam int ENTRY_COUNT_W = 9;
   localparam int REQ_DATA_W = 24;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 24;

   typedef enum logic [1:0] {
      OP_APPEND   = 2'd0,
      OP_REMOVE   = 2'd1,
      OP_POP      = 2'd2,
      OP_CONTAINS = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   typedef struct packed {
      logic [PROC_W-1:0]  proc;
      logic [PAGE_W-1:0]  page;
      logic [FRAME_W-1:0] frame;
   } entry_type;

   typedef struct packed {
      logic       load_req;
      logic       write_tail;
      logic       start_scan;
      logic       run_scan;
      logic       start_pop;
      logic       start_shift_hit;
      logic       run_shift;
      logic       dec_count;
      logic       load_result;
      status_type result_status;
   } ofl_cmd_type;

   typedef struct packed {
      opcode_type op;
      logic       is_full;
      logic       is_empty;
      logic       hit;
      logic       scan_done;
      logic       shift_done;
      logic       out_free;
   } ofl_stat_type;

endpackage

[rtl/ofl_ctrl.sv]
module ofl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  ofl_pkg::ofl_stat_type stat,
   output ofl_pkg::ofl_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_SHIFT,
      S_FINISH
   } state_type;

   state_type           state_ff;
   state_type           state_in;
   ofl_pkg::status_type code_ff;
   ofl_pkg::status_type code_in;

   always_comb begin
      state_in = state_ff;
      code_in = code_ff;
      cmd = '0;
      cmd.result_status = code_ff;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.op)
               ofl_pkg::OP_APPEND: begin
                  if (stat.is_full) begin
                     code_in = ofl_pkg::ST_FULL;
                  end else begin
                     cmd.write_tail = 1'b1;
                     code_in = ofl_pkg::ST_OK;
                  end
                  state_in = S_FINISH;
               end
               ofl_pkg::OP_POP: begin
                  if (stat.is_empty) begin
                     code_in = ofl_pkg::ST_EMPTY;
                     state_in = S_FINISH;
                  end else begin
                     cmd.start_pop = 1'b1;
                     code_in = ofl_pkg::ST_OK;
                     state_in = S_SHIFT;
                  end
               end
               default: begin
                  cmd.start_scan = 1'b1;
                  state_in = S_SCAN;
               end
            endcase
         end
         S_SCAN: begin
            cmd.run_scan = 1'b1;
            if (stat.hit) begin
               code_in = ofl_pkg::ST_OK;
               if (stat.op == ofl_pkg::OP_CONTAINS) begin
                  state_in = S_FINISH;
               end else begin
                  cmd.start_shift_hit = 1'b1;
                  state_in = S_SHIFT;
               end
            end else if (stat.scan_done) begin
               code_in = ofl_pkg::ST_NOT_FOUND;
               state_in = S_FINISH;
            end
         end
         S_SHIFT: begin
            cmd.run_shift = 1'b1;
            if (stat.shift_done) begin
               cmd.dec_count = 1'b1;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.load_result = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff <= ofl_pkg::ST_OK;
      end else begin
         state_ff <= state_in;
         code_ff <= code_in;
      end
   end

endmodule

[rtl/ofl_dpath.sv]
module ofl_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ofl_pkg::opcode_type                  req_opcode,
   input  ofl_pkg::entry_type                   req_entry,
   input  ofl_pkg::ofl_cmd_type                 cmd,
   output ofl_pkg::ofl_stat_type                stat,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output ofl_pkg::status_type                  rsp_status,
   output logic [ofl_pkg::FRAME_W-1:0]          rsp_removed_frame,
   output logic [ofl_pkg::ENTRY_COUNT_W-1:0]    rsp_entry_count
);

   ofl_pkg::entry_type                 mem [ofl_pkg::DEPTH];
   ofl_pkg::entry_type                 rdata_ff;
   ofl_pkg::opcode_type                op_ff;
   ofl_pkg::entry_type                 key_ff;
   logic [ofl_pkg::CNT_W-1:0]          count_ff;
   logic [ofl_pkg::CNT_W-1:0]          count_in;
   logic [ofl_pkg::CNT_W-1:0]          rd_ptr_ff;
   logic [ofl_pkg::CNT_W-1:0]          rd_ptr_in;
   logic [ofl_pkg::IDX_W-1:0]          rd_idx_ff;
   logic                               rd_valid_ff;
   logic                               rd_valid_in;
   logic [ofl_pkg::IDX_W-1:0]          wr_ptr_ff;
   logic [ofl_pkg::IDX_W-1:0]          wr_ptr_in;
   logic [ofl_pkg::FRAME_W-1:0]        removed_ff;
   logic                               rsp_valid_ff;
   ofl_pkg::status_type                rsp_status_ff;
   logic [ofl_pkg::FRAME_W-1:0]        rsp_removed_ff;
   logic [ofl_pkg::ENTRY_COUNT_W-1:0]  rsp_count_ff;
   logic                               rd_issue;
   logic                               shift_wr;
   logic                               wr_en;
   logic [ofl_pkg::IDX_W-1:0]          wr_addr;
   ofl_pkg::entry_type                 wr_data;
   logic                               match;

   assign rd_issue = (cmd.run_scan || cmd.run_shift) && (rd_ptr_ff < count_ff);
   assign shift_wr = cmd.run_shift && rd_valid_ff;
   assign wr_en = cmd.write_tail || shift_wr;
   assign wr_addr = cmd.write_tail ? count_ff[ofl_pkg::IDX_W-1:0] : wr_ptr_ff;
   assign wr_data = cmd.write_tail ? key_ff : rdata_ff;

   assign match = rd_valid_ff && (rdata_ff.frame == key_ff.frame) &&
                  ((op_ff == ofl_pkg::OP_CONTAINS) ||
                   ((rdata_ff.proc == key_ff.proc) && (rdata_ff.page == key_ff.page)));

   always_comb begin
      stat.op = op_ff;
      stat.is_full = (count_ff == ofl_pkg::CNT_W'(ofl_pkg::DEPTH));
      stat.is_empty = (count_ff == '0);
      stat.hit = match;
      stat.scan_done = (rd_ptr_ff == count_ff) && !rd_valid_ff;
      stat.shift_done = (rd_ptr_ff == count_ff) && !rd_valid_ff;
      stat.out_free = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      rd_valid_in = rd_issue;
      wr_ptr_in = wr_ptr_ff;
      count_in = count_ff;
      if (cmd.start_scan) begin
         rd_ptr_in = '0;
         rd_valid_in = 1'b0;
      end else if (cmd.start_pop) begin
         rd_ptr_in = ofl_pkg::CNT_W'(1);
         rd_valid_in = 1'b0;
         wr_ptr_in = '0;
      end else if (cmd.start_shift_hit) begin
         rd_ptr_in = ofl_pkg::CNT_W'(rd_idx_ff) + ofl_pkg::CNT_W'(1);
         rd_valid_in = 1'b0;
         wr_ptr_in = rd_idx_ff;
      end else begin
         if (rd_issue) begin
            rd_ptr_in = rd_ptr_ff + ofl_pkg::CNT_W'(1);
         end
         if (shift_wr) begin
            wr_ptr_in = wr_ptr_ff + ofl_pkg::IDX_W'(1);
         end
      end
      if (cmd.write_tail) begin
         count_in = count_ff + ofl_pkg::CNT_W'(1);
      end else if (cmd.dec_count) begin
         count_in = count_ff - ofl_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_issue) begin
         rdata_ff <= mem[rd_ptr_ff[ofl_pkg::IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff <= rd_ptr_in;
      wr_ptr_ff <= wr_ptr_in;
      rd_idx_ff <= rd_ptr_ff[ofl_pkg::IDX_W-1:0];
      if (cmd.load_req) begin
         op_ff <= req_opcode;
         key_ff <= req_entry;
      end
      if (cmd.load_req) begin
         removed_ff <= '0;
      end else if (cmd.start_shift_hit) begin
         removed_ff <= rdata_ff.frame;
      end
      if (cmd.load_result) begin
         rsp_status_ff <= cmd.result_status;
         rsp_removed_ff <= removed_ff;
         rsp_count_ff <= ofl_pkg::ENTRY_COUNT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rd_valid_ff <= rd_valid_in;
         if (cmd.load_result) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_removed_frame = rsp_removed_ff;
   assign rsp_entry_count = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ofl_pkg::CNT_W'(ofl_pkg::DEPTH))
      else $error("entry count exceeds depth");

   a_no_append_full: assert property (@(posedge clock) disable iff (reset)
      cmd.write_tail |-> (count_ff != ofl_pkg::CNT_W'(ofl_pkg::DEPTH)))
      else $error("append issued on a full list");

   a_result_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_result |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over an untaken word");

   a_shift_order: assert property (@(posedge clock) disable iff (reset)
      shift_wr |-> (wr_ptr_ff < rd_idx_ff))
      else $error("compaction write does not trail its read");

   a_no_dec_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.dec_count |-> (count_ff != '0))
      else $error("entry count decremented below zero");

endmodule

[rtl/ordered_frame_list.sv]
// Channel  Direction  Handshake              Contents
// req      in         req_tvalid/req_tready  operation code, process, page, frame
// rsp      out        rsp_tvalid/rsp_tready  status, removed frame, entry count
//
// Append and a pop on an empty list go from decode straight to finish to load their result.
// Contains and remove walk the list one entry per cycle through the memory read port;
// a remove hit then compacts the entries behind it, as a pop does from the head.
// Reset clears the entry count and the result valid flag; the memory is not cleared.
// A result waiting in the output register stalls only the finish of the next word.
module ordered_frame_list (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // opcode[1:0]
   input  logic [ofl_pkg::REQ_USER_W-1:0] req_tuser,
   // process_index[5:0], page_number[13:6], frame_number[21:14], zeros[23:22]
   input  logic [ofl_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[1:0], removed_frame[9:2], entry_count[18:10], zeros[23:19]
   output logic [ofl_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   ofl_pkg::ofl_cmd_type               cmd;
   ofl_pkg::ofl_stat_type              stat;
   ofl_pkg::entry_type                 req_entry;
   ofl_pkg::opcode_type                req_opcode;
   ofl_pkg::status_type                rsp_status;
   logic [ofl_pkg::FRAME_W-1:0]        rsp_removed_frame;
   logic [ofl_pkg::ENTRY_COUNT_W-1:0]  rsp_entry_count;

   assign req_opcode = ofl_pkg::opcode_type'(req_tuser);
   assign req_entry.proc = req_tdata[5:0];
   assign req_entry.page = req_tdata[13:6];
   assign req_entry.frame = req_tdata[21:14];

   assign rsp_tdata = {5'b0, rsp_entry_count, rsp_removed_frame, rsp_status};

   ofl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ofl_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_opcode        (req_opcode),
      .req_entry         (req_entry),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_valid         (rsp_tvalid),
      .rsp_ready         (rsp_tready),
      .rsp_status        (rsp_status),
      .rsp_removed_frame (rsp_removed_frame),
      .rsp_entry_count   (rsp_entry_count)
   );

endmodule
